>>> rtl/smf_pkg.sv
// ----------------------------------------------------------------------------
// smf_pkg
// Shared constants and types for the substring first-match unit.
// ----------------------------------------------------------------------------
package smf_pkg;

   localparam int MAX_PATTERN    = 64;
   localparam int BYTE_W         = 8;
   localparam int COUNT_W        = 32;
   localparam int REQ_DATA_W     = 8;
   localparam int REQ_USER_W     = 2;
   localparam int RSP_DATA_W     = 32;
   localparam int RSP_USER_W     = 1;

   localparam int USER_CMD_BIT   = 0;
   localparam int USER_EMPTY_BIT = 1;

   localparam logic CMD_PATTERN  = 1'b0;
   localparam logic CMD_HAYSTACK = 1'b1;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   typedef struct packed {
      logic               pat_write;
      logic               hay_shift;
      logic               clear;
      logic [BYTE_W-1:0]  data;
   } lane_ctl_type;

endpackage

>>> rtl/substring_first_match_unit.sv
// ----------------------------------------------------------------------------
// substring_first_match_unit
// Streams pattern bytes then haystack bytes; reports the first match offset.
// ----------------------------------------------------------------------------
//  channel | dir | contents
//  req_    | in  | tdata[7:0] byte, tuser {is_empty, command}, tlast end
//  rsp_    | out | tdata[31:0] match offset, tuser[0] found
//
//  One item per cycle while req_tready is high; each transfer updates the match
//  lanes and counters as taken; a haystack tlast puts a result on rsp_ next cycle.
//  Reset is synchronous and clears lengths, counters and lane state.
//  req_tready drops only while a result is held and rsp_tready is low.
// ----------------------------------------------------------------------------
module substring_first_match_unit #(
   parameter int MaxPattern = smf_pkg::MAX_PATTERN
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [smf_pkg::REQ_DATA_W-1:0]     req_tdata,  // [7:0] byte_value
   input  logic [smf_pkg::REQ_USER_W-1:0]     req_tuser,  // [0] command, [1] is_empty
   input  logic                               req_tlast,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [smf_pkg::RSP_DATA_W-1:0]     rsp_tdata,  // [31:0] match_offset
   output logic [smf_pkg::RSP_USER_W-1:0]     rsp_tuser   // [0] found
);
   import smf_pkg::*;

   localparam int LenW = $clog2(MaxPattern + 1);
   localparam int IdxW = (MaxPattern > 1) ? $clog2(MaxPattern) : 1;

   logic [LenW-1:0]    len_ff, len_in;
   logic               closed_ff, closed_in;
   logic [COUNT_W-1:0] seen_ff, seen_in;
   logic               match_ff, match_in;
   logic [COUNT_W-1:0] offset_ff, offset_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_found_ff;
   logic [COUNT_W-1:0] rsp_offset_ff;

   logic               accept, active, is_hay, is_empty, emit, hit;
   logic               found_now;
   logic [COUNT_W-1:0] offset_now;
   logic [LenW-1:0]    base_len, len_m1;
   lane_ctl_type       ctl;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign is_hay     = (req_tuser[USER_CMD_BIT] == CMD_HAYSTACK);
   assign is_empty   = req_tuser[USER_EMPTY_BIT];
   assign active     = accept && !(is_empty && !req_tlast);
   assign base_len   = closed_ff ? '0 : len_ff;
   assign len_m1     = len_ff - LenW'(1);

   always_comb begin
      len_in     = len_ff;
      closed_in  = closed_ff;
      seen_in    = seen_ff;
      match_in   = match_ff;
      offset_in  = offset_ff;
      emit       = 1'b0;
      found_now  = 1'b0;
      offset_now = '0;
      ctl.pat_write = 1'b0;
      ctl.hay_shift = 1'b0;
      ctl.clear     = 1'b0;
      ctl.data      = req_tdata[BYTE_W-1:0];
      if (active && !is_hay) begin
         ctl.clear = 1'b1;
         seen_in   = '0;
         match_in  = 1'b0;
         offset_in = '0;
         closed_in = req_tlast;
         len_in    = base_len;
         if (!is_empty && (base_len < LenW'(MaxPattern))) begin
            ctl.pat_write = 1'b1;
            len_in        = base_len + LenW'(1);
         end
      end else if (active) begin
         closed_in = 1'b1;
         if (!is_empty) begin
            ctl.hay_shift = 1'b1;
            if (seen_ff != COUNT_MAX) begin
               seen_in = seen_ff + COUNT_W'(1);
            end
            if ((len_ff != '0) && !match_ff && hit) begin
               match_in  = 1'b1;
               offset_in = seen_in - COUNT_W'(len_ff);
            end
         end
         if (req_tlast) begin
            emit       = 1'b1;
            found_now  = (len_ff == '0) || match_in;
            offset_now = ((len_ff != '0) && match_in) ? offset_in : '0;
            ctl.clear  = 1'b1;
            seen_in    = '0;
            match_in   = 1'b0;
            offset_in  = '0;
         end
      end
   end

   assign rsp_valid_in = emit || (rsp_valid_ff && !rsp_tready);

   smf_match_lanes #(
      .MaxPattern (MaxPattern),
      .IdxW       (IdxW)
   ) u_lanes (
      .clock        (clock),
      .reset        (reset),
      .ctl          (ctl),
      .write_index  (base_len[IdxW-1:0]),
      .select_index (len_m1[IdxW-1:0]),
      .hit          (hit)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff       <= '0;
         closed_ff    <= 1'b0;
         seen_ff      <= '0;
         match_ff     <= 1'b0;
         offset_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         len_ff       <= len_in;
         closed_ff    <= closed_in;
         seen_ff      <= seen_in;
         match_ff     <= match_in;
         offset_ff    <= offset_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_found_ff  <= found_now;
         rsp_offset_ff <= offset_now;
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_offset_ff;
   assign rsp_tuser[0] = rsp_found_ff;

endmodule

>>> rtl/smf_match_lanes.sv
// ----------------------------------------------------------------------------
// smf_match_lanes
// Pattern store and per-position prefix match lanes (shift-and).
// ----------------------------------------------------------------------------
module smf_match_lanes #(
   parameter int MaxPattern = smf_pkg::MAX_PATTERN,
   parameter int IdxW       = (MaxPattern > 1) ? $clog2(MaxPattern) : 1
) (
   input  logic                clock,
   input  logic                reset,
   input  smf_pkg::lane_ctl_type ctl,
   input  logic [IdxW-1:0]     write_index,
   input  logic [IdxW-1:0]     select_index,
   output logic                hit
);
   import smf_pkg::*;

   logic [BYTE_W-1:0]     pattern_ff [MaxPattern];
   logic [MaxPattern-1:0] prefix_ff;
   logic [MaxPattern-1:0] prefix_in;
   logic [MaxPattern-1:0] shifted;

   always_comb begin
      for (int j = 0; j < MaxPattern; j++) begin
         if (j == 0) begin
            shifted[j] = (ctl.data == pattern_ff[j]);
         end else begin
            shifted[j] = prefix_ff[j-1] & (ctl.data == pattern_ff[j]);
         end
      end
   end

   assign hit = shifted[select_index];

   always_comb begin
      if (ctl.clear) begin
         prefix_in = '0;
      end else if (ctl.hay_shift) begin
         prefix_in = shifted;
      end else begin
         prefix_in = prefix_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prefix_ff <= '0;
      end else begin
         prefix_ff <= prefix_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.pat_write) begin
         pattern_ff[write_index] <= ctl.data;
      end
   end

endmodule
